// ===== src/pnfb_pkg.sv =====
package pnfb_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DRAW   = 2'd2;
  localparam logic [1:0] CFG_BACK   = 2'd3;

  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Words per row fit in six bits: a 9-bit width register divided by eight
  localparam int WPR_W  = 6;
  // Product of an 8-bit row count and the words per row
  localparam int PROD_W = 14;

  localparam logic [3:0] NIB_MASK = 4'hF;

endpackage

// ===== src/packed_nibble_framebuffer_dirty_rect_unit.sv =====
// Double-buffered 4-bit framebuffer with dirty-rectangle reporting.
//
// Channels: commands enter on s_tvalid/s_tready; s_tuser holds the command kind
// (set pixel, get pixel, fill, flush) and s_tdata the coordinates and
// brightness. Every command returns exactly one result beat on m_tvalid/m_tready.
// Registers are written on the cfg channel, which is always ready.
//
// Sequencing: set and get pixel pass from accept to the result register through
// multiply, read and modify-write steps. Fill walks the N words of the display
// region and flush walks them twice, where N is the number of words in the region;
// one shared buffer port is walked one word per cycle for the compare sweep and
// again for the clear sweep. One command is in flight at a time, so the next
// command is accepted only once the previous result has been registered.
//
// Reset: both buffers are swept to zero, one word per cycle over all
// MAX_WIDTH/8*MAX_HEIGHT words, while s_tready stays low. Config writes are
// taken throughout.
//
// Stall: a finished result holds in the output register while m_tready is low.
// The next command is accepted meanwhile, but its result waits until the
// held beat is taken.
module packed_nibble_framebuffer_dirty_rect_unit
  import pnfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // x[7:0], y[14:8], brightness[18:15]
  input  logic [1:0]            s_tuser,   // kind[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_value[3:0], box_x_start[11:4],
                                           // box_x_end[19:12], box_y_start[26:20],
                                           // box_y_end[33:27]
  output logic                  m_tuser,   // box_empty
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WORDS  = (MAX_WIDTH / 8) * MAX_HEIGHT;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(WORDS + 1);
  localparam int CW     = (CNT_W > PROD_W) ? CNT_W : PROD_W;
  localparam int IW     = CW + 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_PRD  = 3'd3;
  localparam logic [2:0] ST_PWR  = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_FILL = 3'd6;
  localparam logic [2:0] ST_RESP = 3'd7;

  logic [2:0] state;

  // Configuration registers
  logic [8:0] frame_width;
  logic [7:0] frame_height;
  logic [3:0] draw_color;
  logic [3:0] background_color;

  // Latched command
  logic [1:0] op_kind;
  logic [7:0] op_x;
  logic [6:0] op_y;
  logic [3:0] op_br;

  // Sequencer state
  logic [CW-1:0]     cnt;
  logic [PROD_W-1:0] prod;
  logic              in_rng;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [3:0]        fill_col;
  logic              cur_b;
  logic [WPR_W-1:0]  col;
  logic [7:0]        row;
  logic              pend;
  logic [WPR_W-1:0]  pend_col;
  logic [7:0]        pend_row;
  logic              found;

  // Result staging
  logic [3:0]       res_pix;
  logic             res_empty;
  logic [WPR_W-1:0] res_xs;
  logic [WPR_W-1:0] res_xe;
  logic [7:0]       res_ys;
  logic [7:0]       res_ye;

  // Buffers
  logic [31:0] mem_a [WORDS];
  logic [31:0] mem_b [WORDS];
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        we_a;
  logic        we_b;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [31:0] wdata;

  // Effective geometry
  logic [8:0]       w_clamp;
  logic [8:0]       w_eff;
  logic [WPR_W-1:0] wpr;
  logic [7:0]       h_eff;

  // Shared multiplier
  logic [7:0]        mul_a;
  logic [PROD_W-1:0] mul_p;

  logic [IW-1:0] pix_idx;
  logic [31:0]   rd_cur;
  logic [31:0]   set_word;
  logic          cnt_lt_n;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    w_clamp = (int'(frame_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width;
    wpr     = w_clamp[8:3];
    w_eff   = {wpr, 3'b000};
    h_eff   = (int'(frame_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : frame_height;
  end

  // One multiplier: row offset for pixel commands, region size for sweeps
  assign mul_a = (op_kind == KIND_SET || op_kind == KIND_GET) ? {1'b0, op_y} : h_eff;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(wpr);

  assign pix_idx  = IW'(prod) + IW'(op_x[7:3]);
  assign cnt_lt_n = (cnt < CW'(prod));
  assign rd_cur   = cur_b ? rd_b : rd_a;

  always_comb begin
    set_word = rd_cur;
    set_word[{op_x[2:0], 2'b00} +: 4] = op_br;
  end

  // Buffer port control
  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    waddr = cnt[ADDR_W-1:0];
    wdata = '0;
    raddr = cnt[ADDR_W-1:0];
    case (state)
      ST_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
      end
      ST_FILL: begin
        we_a  = cnt_lt_n && !cur_b;
        we_b  = cnt_lt_n && cur_b;
        wdata = {8{fill_col}};
      end
      ST_PRD: begin
        raddr = pix_idx[ADDR_W-1:0];
      end
      ST_PWR: begin
        we_a  = (op_kind == KIND_SET) && pix_ok && !cur_b;
        we_b  = (op_kind == KIND_SET) && pix_ok && cur_b;
        waddr = pix_addr;
        wdata = set_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rd_a <= mem_a[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rd_b <= mem_b[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLR;
      cnt              <= '0;
      cur_b            <= 1'b0;
      m_tvalid         <= 1'b0;
      pend             <= 1'b0;
      frame_width      <= 9'd256;
      frame_height     <= 8'd128;
      draw_color       <= 4'd15;
      background_color <= 4'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  frame_width      <= cfg_data;
          CFG_HEIGHT: frame_height     <= cfg_data[7:0];
          CFG_DRAW:   draw_color       <= cfg_data[3:0];
          CFG_BACK:   background_color <= cfg_data[3:0];
          default:    frame_width      <= frame_width;
        endcase
      end

      // Drop the output beat once taken; the result state reloads it itself
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLR: begin
          // Sweep both buffers to zero after reset
          if (cnt == CW'(WORDS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            op_kind <= s_tuser;
            op_x    <= s_tdata[7:0];
            op_y    <= s_tdata[14:8];
            op_br   <= s_tdata[18:15];
            state   <= ST_PREP;
          end
        end

        ST_PREP: begin
          prod      <= mul_p;
          in_rng    <= ({1'b0, op_x} < w_eff) && ({1'b0, op_y} < h_eff);
          fill_col  <= (op_kind == KIND_FILL) ? draw_color : background_color;
          res_pix   <= '0;
          res_empty <= 1'b0;
          res_xs    <= '0;
          res_xe    <= '0;
          res_ys    <= '0;
          res_ye    <= '0;
          found     <= 1'b0;
          pend      <= 1'b0;
          cnt       <= '0;
          row       <= '0;
          col       <= '0;
          case (op_kind)
            KIND_SET, KIND_GET: state <= ST_PRD;
            KIND_FILL:          state <= ST_FILL;
            default:            state <= ST_SCAN;
          endcase
        end

        ST_PRD: begin
          // Read issued this cycle; hold the address for the write-back
          pix_addr <= pix_idx[ADDR_W-1:0];
          pix_ok   <= in_rng && (pix_idx < IW'(WORDS));
          state    <= ST_PWR;
        end

        ST_PWR: begin
          if (op_kind == KIND_GET && pix_ok) begin
            res_pix <= rd_cur[{op_x[2:0], 2'b00} +: 4] & NIB_MASK;
          end
          state <= ST_RESP;
        end

        ST_SCAN: begin
          // Compare the word read last cycle
          if (pend && (rd_a != rd_b)) begin
            if (!found) begin
              found  <= 1'b1;
              res_xs <= pend_col;
              res_xe <= pend_col;
              res_ys <= pend_row;
              res_ye <= pend_row;
            end else begin
              if (pend_col < res_xs) res_xs <= pend_col;
              if (pend_col > res_xe) res_xe <= pend_col;
              res_ye <= pend_row;
            end
          end
          // Issue the next word in raster order
          if (cnt_lt_n) begin
            pend     <= 1'b1;
            pend_col <= col;
            pend_row <= row;
            cnt      <= cnt + 1'b1;
            if (col == wpr - 1'b1) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              // Sweep done: swap and clear the new current buffer
              res_empty <= !found;
              cur_b     <= !cur_b;
              cnt       <= '0;
              state     <= ST_FILL;
            end
          end
        end

        ST_FILL: begin
          if (cnt_lt_n) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_empty;
            m_tdata  <= {6'b0,
                         res_ye[6:0],
                         res_ys[6:0],
                         8'({res_xe, 3'b000}),
                         8'({res_xs, 3'b000}),
                         res_pix};
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/packed_nibble_framebuffer_dirty_rect_unit_tb.sv =====
`timescale 1ns / 1ps

module packed_nibble_framebuffer_dirty_rect_unit_tb;
  import pnfb_pkg::*;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 128;
  localparam int FB_WORDS    = MAX_W / 8 * MAX_H;
  // Slowest legal run stays well under this even with full-size sweeps and long stalls
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_STALL  = 400;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [6:0] y;
    logic [3:0] bright;
  } fb_cmd_t;

  typedef struct packed {
    logic [3:0] pixel;
    logic       empty;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [6:0] y_start;
    logic [6:0] y_end;
  } fb_reply_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // x[7:0], y[14:8], brightness[18:15]
  logic [1:0]            s_tuser   = KIND_SET;  // kind[1:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // pixel_value[3:0], box_x_start[11:4], box_x_end[19:12],
                                    // box_y_start[26:20], box_y_end[33:27]
  logic                  m_tuser;   // box_empty
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  packed_nibble_framebuffer_dirty_rect_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of both frame buffers; shadow_cur selects the one being drawn into
  logic [31:0] shadow_fb [2][FB_WORDS];
  bit          shadow_cur;
  logic [8:0]  reg_width;
  logic [7:0]  reg_height;
  logic [3:0]  reg_draw;
  logic [3:0]  reg_back;

  // Replies owed by the block, oldest first
  fb_reply_t replies_due[$];

  int err_count     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Each bump of stall_order asks the receiver for one long hold-off
  int stall_order   = 0;
  int stall_served  = 0;
  int stall_left    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the framebuffer
  // ---------------------------------------------------------------------------

  // Width in use: clamp to the buffer, then drop to a whole number of words
  function automatic int region_width();
    int w;
    w = (reg_width > MAX_W) ? MAX_W : reg_width;
    return w & ~7;
  endfunction

  function automatic int region_height();
    return (reg_height > MAX_H) ? MAX_H : reg_height;
  endfunction

  // Fill and the post-flush clear touch only the display region, in word order
  function automatic void paint_region(bit sel, logic [3:0] color);
    int n;
    n = (region_width() / 8) * region_height();
    for (int i = 0; i < n; i++) shadow_fb[sel][i] = {8{color}};
  endfunction

  function automatic fb_reply_t predict_reply(fb_cmd_t c);
    fb_reply_t r;
    int        w;
    int        h;
    int        wpr;
    int        idx;
    int        sh;
    int        px;
    bit        found;
    r     = '0;
    w     = region_width();
    h     = region_height();
    wpr   = w / 8;
    idx   = 0;
    found = 1'b0;
    case (c.kind)
      KIND_SET, KIND_GET: begin
        // Out-of-range coordinates: set is dropped, get reads back zero
        if (c.x < w && c.y < h) begin
          idx = c.y * wpr + c.x / 8;
          sh  = (c.x % 8) * 4;
          if (c.kind == KIND_SET) shadow_fb[shadow_cur][idx][sh +: 4] = c.bright;
          else r.pixel = shadow_fb[shadow_cur][idx][sh +: 4];
        end
      end
      KIND_FILL: paint_region(shadow_cur, reg_draw);
      default: begin
        // Raster walk over the region, growing the box around changed words
        for (int row = 0; row < h; row++) begin
          for (int col = 0; col < wpr; col++) begin
            if (shadow_fb[shadow_cur][idx] != shadow_fb[!shadow_cur][idx]) begin
              px = col * 8;
              if (!found) begin
                r.x_start = 8'(px);
                r.x_end   = 8'(px);
                r.y_start = 7'(row);
                r.y_end   = 7'(row);
                found     = 1'b1;
              end else begin
                if (px < r.x_start) r.x_start = 8'(px);
                if (px > r.x_end)   r.x_end   = 8'(px);
                r.y_end = 7'(row);
              end
            end
            idx++;
          end
        end
        r.empty    = !found;
        shadow_cur = !shadow_cur;
        paint_region(shadow_cur, reg_back);
      end
    endcase
    return r;
  endfunction

  // Mostly in-range pixel traffic; the rest lands anywhere in the field range
  function automatic fb_cmd_t random_command(int fill_pct, int flush_pct);
    fb_cmd_t c;
    int      roll;
    int      w;
    int      h;
    w        = region_width();
    h        = region_height();
    roll     = $urandom_range(99);
    c.x      = 8'($urandom);
    c.y      = 7'($urandom);
    c.bright = 4'($urandom);
    if (roll < fill_pct) c.kind = KIND_FILL;
    else if (roll < fill_pct + flush_pct) c.kind = KIND_FLUSH;
    else if (roll < 60) c.kind = KIND_SET;
    else c.kind = KIND_GET;
    if (w > 0 && h > 0 && $urandom_range(99) < 85) begin
      c.x = 8'($urandom_range(w - 1));
      c.y = 7'($urandom_range(h - 1));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one command beat; tvalid stays high on return so back-to-back beats
  // need no extra edge. Anything that stops sending lowers it first.
  task automatic issue(logic [1:0] kind, logic [7:0] x, logic [6:0] y, logic [3:0] bright);
    fb_cmd_t c;
    c = '{kind, x, y, bright};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, bright, y, x};
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(predict_reply(c));
  endtask

  task automatic cfg_beat(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  reg_width  = val[8:0];
      CFG_HEIGHT: reg_height = val[7:0];
      CFG_DRAW:   reg_draw   = val[3:0];
      CFG_BACK:   reg_back   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [8:0] w_px, logic [7:0] h_rows, logic [3:0] draw,
                            logic [3:0] back);
    cfg_beat(CFG_WIDTH, w_px);
    cfg_beat(CFG_HEIGHT, {1'b0, h_rows});
    cfg_beat(CFG_DRAW, {5'b0, draw});
    cfg_beat(CFG_BACK, {5'b0, back});
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, drain every owed reply and let the block settle back to ready
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0 || !s_tready);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: long hold-off on request, otherwise random stalls at the set rate
  always @(posedge clk) begin
    if (stall_order != stall_served) begin
      stall_served = stall_order;
      stall_left   = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fb_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        err_count++;
        $display("%0t unexpected result beat: expected none, actual tdata %0h tuser %0b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = replies_due.pop_front();
        check_field("pixel_value", want.pixel, m_tdata[3:0]);
        check_field("box_empty", want.empty, m_tuser);
        check_field("box_x_start", want.x_start, m_tdata[11:4]);
        check_field("box_x_end", want.x_end, m_tdata[19:12]);
        check_field("box_y_start", want.y_start, m_tdata[26:20]);
        check_field("box_y_end", want.y_end, m_tdata[33:27]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_nibble_framebuffer_dirty_rect_unit_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh buffers read zero and a flush of two cleared buffers is empty
  task automatic test_reset_state();
    issue(KIND_GET, 8'd0, 7'd0, 4'h0);
    issue(KIND_GET, 8'd255, 7'd127, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
  endtask

  // Even and odd nibbles at both corners, read back, then a full-size flush
  task automatic test_pixel_access();
    issue(KIND_SET, 8'd0, 7'd0, 4'hF);
    issue(KIND_SET, 8'd1, 7'd0, 4'hA);
    issue(KIND_SET, 8'd255, 7'd127, 4'h5);
    issue(KIND_SET, 8'd254, 7'd127, 4'hC);
    issue(KIND_GET, 8'd0, 7'd0, 4'h0);
    issue(KIND_GET, 8'd1, 7'd0, 4'h0);
    issue(KIND_GET, 8'd255, 7'd127, 4'h0);
    issue(KIND_GET, 8'd254, 7'd127, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
  endtask

  // Fill and background clear on a small region; words past it keep old data
  task automatic test_fill_flush();
    wait_idle();
    write_regs(9'd16, 8'd2, 4'd6, 4'd9);
    issue(KIND_FILL, 8'd0, 7'd0, 4'h0);
    issue(KIND_GET, 8'd3, 7'd1, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
    issue(KIND_GET, 8'd3, 7'd1, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
  endtask

  // Zero-size region, then clipping just past the right and bottom edges
  task automatic test_clip_and_empty();
    wait_idle();
    write_regs(9'd7, 8'd0, 4'd12, 4'd4);
    issue(KIND_SET, 8'd0, 7'd0, 4'h3);
    issue(KIND_GET, 8'd0, 7'd0, 4'h0);
    issue(KIND_FILL, 8'd0, 7'd0, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
    wait_idle();
    write_regs(9'd24, 8'd5, 4'd1, 4'd14);
    issue(KIND_SET, 8'd24, 7'd0, 4'h7);
    issue(KIND_SET, 8'd0, 7'd5, 4'h7);
    issue(KIND_GET, 8'd24, 7'd0, 4'h0);
    issue(KIND_GET, 8'd23, 7'd4, 4'h0);
    issue(KIND_FLUSH, 8'd0, 7'd0, 4'h0);
  endtask

  // Hold the result side off long enough that the input backs up, then pause
  // the sender until everything is drained and stream again
  task automatic test_backpressure();
    fb_cmd_t c;
    wait_idle();
    write_regs(9'd64, 8'd8, 4'd10, 4'd5);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_order   <= stall_order + 1;
    repeat (20) begin
      c = random_command(0, 0);
      issue(c.kind, c.x, c.y, c.bright);
    end
    wait_idle();
    repeat (20) begin
      c = random_command(5, 5);
      issue(c.kind, c.x, c.y, c.bright);
    end
  endtask

  task automatic run_setting(logic [8:0] w_px, logic [7:0] h_rows, logic [3:0] draw,
                             logic [3:0] back, int count, int fill_pct, int flush_pct);
    fb_cmd_t c;
    wait_idle();
    write_regs(w_px, h_rows, draw, back);
    repeat (count) begin
      c = random_command(fill_pct, flush_pct);
      issue(c.kind, c.x, c.y, c.bright);
    end
  endtask

  // Three idling regimes, each over several sizes; full-size regions get few
  // fills and flushes since those walk the whole buffer
  task automatic test_random_traffic();
    send_idle_pct = 36;
    recv_idle_pct <= 77;
    run_setting(9'd64, 8'd8, 4'd3, 4'd12, 150, 3, 4);
    run_setting(9'd511, 8'd255, 4'd15, 4'd0, 120, 1, 2);
    run_setting(9'd40, 8'd20, 4'd9, 4'd6, 180, 3, 4);
    send_idle_pct = 77;
    recv_idle_pct <= 36;
    run_setting(9'd256, 8'd128, 4'd0, 4'd15, 100, 1, 2);
    run_setting(9'd8, 8'd1, 4'd5, 4'd10, 150, 5, 5);
    run_setting(9'd135, 8'd37, 4'd7, 4'd1, 200, 2, 3);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_setting(9'd5, 8'd200, 4'd2, 4'd8, 60, 5, 5);
    run_setting(9'd24, 8'd128, 4'd12, 4'd3, 200, 3, 4);
    run_setting(9'd248, 8'd3, 4'd15, 4'd15, 190, 3, 4);
  endtask

  initial begin
    for (int i = 0; i < FB_WORDS; i++) begin
      shadow_fb[0][i] = '0;
      shadow_fb[1][i] = '0;
    end
    shadow_cur = 1'b0;
    reg_width  = 9'd256;
    reg_height = 8'd128;
    reg_draw   = 4'd15;
    reg_back   = 4'd0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Ride out the buffer-clearing sweep that follows reset
    do @(posedge clk); while (!s_tready);

    test_reset_state();
    test_pixel_access();
    test_fill_flush();
    test_clip_and_empty();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("packed_nibble_framebuffer_dirty_rect_unit_tb OK");
    end else begin
      $display("packed_nibble_framebuffer_dirty_rect_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
